// ===== rtl/core/nsr_pkg.sv =====
// shared types for the fixed point square root block
`timescale 1ns / 1ps

package nsr_pkg;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
  } nsr_cmd_t;

endpackage

// ===== rtl/core/nsr_ctrl.sv =====
// sequencer for the digit recurrence and the output beat handshake
`timescale 1ns / 1ps

module nsr_ctrl #(
  parameter int PAIR_COUNT = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nsr_pkg::nsr_cmd_t cmd_o
);
  import nsr_pkg::*;

  localparam int CNT_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             last;
  logic             free;

  assign last = (cnt_q == '0);
  assign free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step  = (state_q == ST_CALC) && (!last || free);
    cmd_o.store = (state_q == ST_CALC) && last && free;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
          cnt_d   = CNT_W'(PAIR_COUNT - 1);
        end
      end
      ST_CALC: begin
        if (cmd_o.store) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end else if (cmd_o.step) begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/nsr_datapath.sv =====
// restoring root recurrence, one result bit per step, with output register
`timescale 1ns / 1ps

module nsr_datapath #(
  parameter int FRAC_BITS  = 16,
  parameter int INPUT_BITS = 31,
  parameter int PAIR_COUNT = 32
) (
  input  logic              clk_i,
  input  nsr_pkg::nsr_cmd_t cmd_i,
  input  logic [30:0]       value_i,
  output logic [31:0]       root_o,
  output logic              exact_o
);
  import nsr_pkg::*;

  localparam int VAL_W = (INPUT_BITS < 31) ? INPUT_BITS : 31;
  localparam int SV_W  = 2 * PAIR_COUNT;
  localparam int ACC_W = PAIR_COUNT;
  localparam int REM_W = PAIR_COUNT + 2;

  logic [SV_W-1:0]  sv_q;
  logic [ACC_W-1:0] acc_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             ge;
  logic [63:0]      acc_ext;
  logic             sat;
  logic [31:0]      root_q;
  logic             exact_q;

  assign rem_shift = {rem_q[REM_W-3:0], sv_q[SV_W-1 -: 2]};
  assign trial     = {acc_q, 2'b01};
  assign ge        = (rem_shift >= trial);
  assign diff      = rem_shift - trial;

  assign acc_ext = 64'(acc_q);
  assign sat     = (acc_ext[63:32] != 32'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sv_q  <= SV_W'(value_i[VAL_W-1:0]) << (2 * FRAC_BITS);
      acc_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      sv_q  <= {sv_q[SV_W-3:0], 2'b00};
      acc_q <= {acc_q[ACC_W-2:0], ge};
      rem_q <= ge ? diff : rem_shift;
    end
  end

  // final step result goes straight into the output register
  logic [ACC_W-1:0] acc_fin;
  logic [REM_W-1:0] rem_fin;
  logic [63:0]      fin_ext;
  logic             fin_sat;

  assign acc_fin = {acc_q[ACC_W-2:0], ge};
  assign rem_fin = ge ? diff : rem_shift;
  assign fin_ext = 64'(acc_fin);
  assign fin_sat = (fin_ext[63:32] != 32'd0) || sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      root_q  <= fin_sat ? 32'hFFFF_FFFF : fin_ext[31:0];
      exact_q <= !fin_sat && (rem_fin == '0);
    end
  end

  assign root_o  = root_q;
  assign exact_o = exact_q;

endmodule

// ===== rtl/core/newton_square_root.sv =====
// top level of the fixed point square root block
// the input beat is loaded, then a single compare and subtract unit runs the
//   restoring recurrence over PAIR_COUNT = (INPUT_BITS + 2*FRAC_BITS + 1) / 2
//   bit pairs (32 by default), one root bit per cycle; the last bit waits while
//   the output beat is held, and no new input is taken before the result is stored
// reset: asynchronous active low, clears the sequencer and the output valid flag
`timescale 1ns / 1ps

module newton_square_root #(
  parameter int FRAC_BITS  = 16,
  parameter int INPUT_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[30:0], pad[31]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // root[31:0], exact[32], pad[39:33]
);
  import nsr_pkg::*;

  localparam int PAIR_COUNT = (INPUT_BITS + 2 * FRAC_BITS + 1) / 2;

  nsr_cmd_t    cmd;
  logic [31:0] root;
  logic        exact;

  nsr_ctrl #(
    .PAIR_COUNT(PAIR_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  nsr_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .INPUT_BITS(INPUT_BITS),
    .PAIR_COUNT(PAIR_COUNT)
  ) u_datapath (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .value_i(s_axis_tdata[30:0]),
    .root_o (root),
    .exact_o(exact)
  );

  assign m_axis_tdata = {7'd0, exact, root};

endmodule

// ===== dv/tb_newton_square_root.sv =====
// testbench for the fixed point square root block: predicts every root and checks each beat
`timescale 1ns / 1ps

module tb_newton_square_root;

  localparam int FRAC_BITS   = 16;
  localparam int INPUT_BITS  = 31;
  localparam int PAIR_COUNT  = (INPUT_BITS + 2 * FRAC_BITS + 1) / 2;
  localparam int DRAIN_WAIT  = PAIR_COUNT + 8;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int CHUNK_ITEMS = 725;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [INPUT_BITS-1:0] value;
    logic [31:0]           root;
    logic                  exact;
  } root_expect_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // value[30:0], pad[31]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // root[31:0], exact[32], pad[39:33]

  logic [INPUT_BITS-1:0] pending_values[$];
  root_expect_t          expected_roots[$];

  int unsigned send_wait = 0;
  int unsigned send_calm = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;
  int unsigned hold_left = 0;
  int unsigned values_sent = 0;
  int unsigned roots_checked = 0;
  int unsigned exact_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  newton_square_root #(
    .FRAC_BITS (FRAC_BITS),
    .INPUT_BITS(INPUT_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // restoring digit recurrence, one root bit per pair of scaled input bits
  function automatic root_expect_t predict_root(logic [INPUT_BITS-1:0] value);
    logic [63:0]  scaled;
    logic [63:0]  rem;
    logic [63:0]  acc;
    logic [63:0]  trial;
    root_expect_t res;
    scaled = 64'(value) << (2 * FRAC_BITS);
    rem = '0;
    acc = '0;
    for (int i = PAIR_COUNT - 1; i >= 0; i--) begin
      rem = (rem << 2) | 64'(scaled[2*i +: 2]);
      trial = (acc << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        acc = (acc << 1) | 64'd1;
      end else begin
        acc = acc << 1;
      end
    end
    res.value = value;
    if (acc > 64'hFFFF_FFFF) begin
      res.root = '1;
      res.exact = 1'b0;
    end else begin
      res.root = acc[31:0];
      res.exact = (rem == 0);
    end
    return res;
  endfunction

  // idle cycles before the next beat, with occasional stretches of none
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [INPUT_BITS-1:0] random_value();
    int unsigned k;
    int unsigned sq;
    logic [INPUT_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = INPUT_BITS'($urandom);
      4, 5:       v = INPUT_BITS'($urandom_range(0, 1023));
      6, 7: begin
        k = $urandom_range(0, 46340);
        sq = k * k;
        case ($urandom_range(0, 3))
          0:       v = INPUT_BITS'(sq - 1);
          1:       v = INPUT_BITS'(sq + 1);
          default: v = INPUT_BITS'(sq);
        endcase
      end
      8: begin
        v = INPUT_BITS'(1) << $urandom_range(0, INPUT_BITS - 1);
        if ($urandom_range(0, 1) == 1) v = ~v;
      end
      default: v = '1 - INPUT_BITS'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < 10) $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  always @(posedge clk_i) begin : driver
    logic fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (fire) begin
        expected_roots.push_back(predict_root(s_axis_tdata[INPUT_BITS-1:0]));
        values_sent++;
        send_wait = draw_gap(send_calm);
      end
      if (!s_axis_tvalid || fire) begin
        if (send_wait == 0 && pending_values.size() > 0) begin
          s_axis_tdata <= {1'b0, pending_values.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    root_expect_t want;
    logic [31:0]  got_root;
    logic         got_exact;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_root = m_axis_tdata[31:0];
        got_exact = m_axis_tdata[32];
        if (expected_roots.size() == 0) begin
          note_failure($sformatf("result beat with nothing pending: root %0d exact %0b",
                                 got_root, got_exact));
        end else begin
          want = expected_roots.pop_front();
          if (got_root !== want.root)
            note_failure($sformatf("root of %0d: expected %0d, got %0d",
                                   want.value, want.root, got_root));
          if (got_exact !== want.exact)
            note_failure($sformatf("exact flag of %0d: expected %0b, got %0b",
                                   want.value, want.exact, got_exact));
          if (want.exact) exact_seen++;
        end
        roots_checked++;
        recv_wait = draw_gap(recv_calm);
        if (roots_checked == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_roots.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_all_done();
    while (pending_values.size() > 0 || s_axis_tvalid || expected_roots.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero, small values, perfect squares and neighbors, bit patterns, the top of range
    pending_values.push_back(31'd0);
    pending_values.push_back(31'd1);
    pending_values.push_back(31'd2);
    pending_values.push_back(31'd3);
    pending_values.push_back(31'd4);
    pending_values.push_back(31'd9);
    pending_values.push_back(31'd15);
    pending_values.push_back(31'd16);
    pending_values.push_back(31'd17);
    pending_values.push_back(31'd65536);
    pending_values.push_back(31'h4000_0000);
    pending_values.push_back(31'h3FFF_FFFF);
    pending_values.push_back(31'd2147395599);
    pending_values.push_back(31'd2147395600);
    pending_values.push_back(31'd2147395601);
    pending_values.push_back(31'h5555_5555);
    pending_values.push_back(31'h2AAA_AAAA);
    pending_values.push_back(31'h7FFF_FFFE);
    pending_values.push_back(31'h7FFF_FFFF);
    pending_values.push_back(31'd1000000);
    wait_all_done();

    // two random chunks, the sender pausing in between until all roots are back
    for (int chunk = 0; chunk < 2; chunk++) begin
      @(negedge clk_i);
      for (int n = 0; n < CHUNK_ITEMS; n++) pending_values.push_back(random_value());
      wait_all_done();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("sent %0d values (edges, perfect squares and neighbors, bit patterns, random)",
             values_sent);
    $display("checked %0d roots, %0d exact, %0d mismatches", roots_checked, exact_seen,
             fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
